FILE: src/plpu_pkg.sv
// Shared constants, types and the control-store program of the piecewise-linear profile unit.
// Depends on nothing; the design files refer to it by scoped names and the checker imports it.
`default_nettype none

package plpu_pkg;

  localparam int MAX_POINTS    = 16;
  localparam int VALUE_BITS    = 32;
  localparam int IDX_BITS      = $clog2(MAX_POINTS);
  localparam int NUM_BITS      = $clog2(MAX_POINTS + 1);
  localparam int DIFF_BITS     = VALUE_BITS + 1;
  localparam int MAG_BITS      = DIFF_BITS;
  localparam int PROD_BITS     = 2 * MAG_BITS;
  localparam int SUM_BITS      = PROD_BITS + 2;
  localparam int CNT_BITS      = $clog2(PROD_BITS + MAX_POINTS);
  localparam int ACTION_W      = 2;
  localparam int INDEX_W       = 4;
  localparam int POINTS_W      = 5;
  localparam int IN_DATA_BITS  = ((INDEX_W + 3 * VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
  localparam int UPC_BITS      = 4;

  localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FWD  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REV  = 2'd2;

  localparam logic [POINTS_W-1:0] POINTS_RESET = 5'd2;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_RD_FIRST,
    OP_RD_LAST,
    OP_DIR,
    OP_SRCH_RD,
    OP_SRCH_CMP,
    OP_SEG_RD0,
    OP_SEG_RD1,
    OP_SEG_LATCH,
    OP_DIFF,
    OP_MUL,
    OP_DIV,
    OP_FIN,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_GOTO,
    COND_NO_START,
    COND_CNT_ZERO,
    COND_KEY_GE,
    COND_SPAN_ZERO,
    COND_CNT_NZ,
    COND_OUT_FREE
  } cond_t;

  typedef logic [UPC_BITS-1:0] upc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    logic start;
    logic cnt_zero;
    logic key_ge;
    logic span_zero;
    logic out_free;
  } status_t;

  localparam upc_t ST_IDLE      = 4'd0;
  localparam upc_t ST_RD_FIRST  = 4'd1;
  localparam upc_t ST_RD_LAST   = 4'd2;
  localparam upc_t ST_DIR       = 4'd3;
  localparam upc_t ST_SRCH_RD   = 4'd4;
  localparam upc_t ST_SRCH_CMP  = 4'd5;
  localparam upc_t ST_SEG_RD0   = 4'd6;
  localparam upc_t ST_SEG_RD1   = 4'd7;
  localparam upc_t ST_SEG_LATCH = 4'd8;
  localparam upc_t ST_DIFF      = 4'd9;
  localparam upc_t ST_MUL       = 4'd10;
  localparam upc_t ST_DIV       = 4'd11;
  localparam upc_t ST_FIN       = 4'd12;
  localparam upc_t ST_WAIT      = 4'd13;

  // Control store: a false condition falls through to the next step.
  function automatic uword_t ucode(input upc_t step);
    uword_t w;
    unique case (step)
      ST_IDLE:      w = '{OP_IDLE,      COND_NO_START,  ST_IDLE};
      ST_RD_FIRST:  w = '{OP_RD_FIRST,  COND_NEXT,      ST_IDLE};
      ST_RD_LAST:   w = '{OP_RD_LAST,   COND_NEXT,      ST_IDLE};
      ST_DIR:       w = '{OP_DIR,       COND_NEXT,      ST_IDLE};
      ST_SRCH_RD:   w = '{OP_SRCH_RD,   COND_CNT_ZERO,  ST_SEG_RD0};
      ST_SRCH_CMP:  w = '{OP_SRCH_CMP,  COND_KEY_GE,    ST_SRCH_RD};
      ST_SEG_RD0:   w = '{OP_SEG_RD0,   COND_NEXT,      ST_IDLE};
      ST_SEG_RD1:   w = '{OP_SEG_RD1,   COND_NEXT,      ST_IDLE};
      ST_SEG_LATCH: w = '{OP_SEG_LATCH, COND_NEXT,      ST_IDLE};
      ST_DIFF:      w = '{OP_DIFF,      COND_NEXT,      ST_IDLE};
      ST_MUL:       w = '{OP_MUL,       COND_SPAN_ZERO, ST_FIN};
      ST_DIV:       w = '{OP_DIV,       COND_CNT_NZ,    ST_DIV};
      ST_FIN:       w = '{OP_FIN,       COND_OUT_FREE,  ST_IDLE};
      ST_WAIT:      w = '{OP_NOP,       COND_GOTO,      ST_FIN};
      default:      w = '{OP_NOP,       COND_GOTO,      ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: src/plpu_table.sv
// Breakpoint store: two arrays of x and y, one write port and one registered read port.
// Depends on plpu_pkg for sizes.
`default_nettype none

module plpu_table (
  input  wire                                          clk,
  input  wire                                          wr_en,
  input  wire  [plpu_pkg::IDX_BITS-1:0]                wr_idx,
  input  wire  logic signed [plpu_pkg::VALUE_BITS-1:0] wr_x,
  input  wire  logic signed [plpu_pkg::VALUE_BITS-1:0] wr_y,
  input  wire  [plpu_pkg::IDX_BITS-1:0]                rd_idx,
  output logic signed [plpu_pkg::VALUE_BITS-1:0]       rd_x,
  output logic signed [plpu_pkg::VALUE_BITS-1:0]       rd_y
);

  logic signed [plpu_pkg::VALUE_BITS-1:0] mem_x [plpu_pkg::MAX_POINTS];
  logic signed [plpu_pkg::VALUE_BITS-1:0] mem_y [plpu_pkg::MAX_POINTS];
  logic signed [plpu_pkg::VALUE_BITS-1:0] rd_x_r;
  logic signed [plpu_pkg::VALUE_BITS-1:0] rd_y_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_idx] <= wr_x;
      mem_y[wr_idx] <= wr_y;
    end
    rd_x_r <= mem_x[rd_idx];
    rd_y_r <= mem_y[rd_idx];
  end

  assign rd_x = rd_x_r;
  assign rd_y = rd_y_r;

endmodule

`default_nettype wire

FILE: src/plpu_seq.sv
// Microsequencer: step counter, control-store lookup and jump-condition select.
// Depends on plpu_pkg for the control word, status struct and program.
`default_nettype none

module plpu_seq (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire  plpu_pkg::status_t  status,
  output plpu_pkg::uword_t         uw
);

  plpu_pkg::upc_t upc_r;
  plpu_pkg::upc_t upc_nxt;
  logic           take;

  always_comb begin
    uw = plpu_pkg::ucode(upc_r);
    unique case (uw.cond)
      plpu_pkg::COND_NEXT:      take = 1'b0;
      plpu_pkg::COND_GOTO:      take = 1'b1;
      plpu_pkg::COND_NO_START:  take = !status.start;
      plpu_pkg::COND_CNT_ZERO:  take = status.cnt_zero;
      plpu_pkg::COND_KEY_GE:    take = status.key_ge;
      plpu_pkg::COND_SPAN_ZERO: take = status.span_zero;
      plpu_pkg::COND_CNT_NZ:    take = !status.cnt_zero;
      plpu_pkg::COND_OUT_FREE:  take = status.out_free;
      default:                  take = 1'b1;
    endcase
    upc_nxt = take ? uw.target : upc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= plpu_pkg::ST_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/plpu_dp.sv
// Datapath: segment search registers, difference stage, multiplier, bit-serial divider
// and the saturating output register. Driven by the control word from plpu_seq.
`default_nettype none

module plpu_dp (
  input  wire                                          clk,
  input  wire                                          rst_n,
  input  wire  plpu_pkg::op_t                          op,
  input  wire                                          start,
  input  wire                                          start_rev,
  input  wire  logic signed [plpu_pkg::VALUE_BITS-1:0] query,
  input  wire  [plpu_pkg::POINTS_W-1:0]                points,
  input  wire  logic signed [plpu_pkg::VALUE_BITS-1:0] rd_x,
  input  wire  logic signed [plpu_pkg::VALUE_BITS-1:0] rd_y,
  output logic [plpu_pkg::IDX_BITS-1:0]                rd_idx,
  output plpu_pkg::status_t                            status,
  input  wire                                          out_ready,
  output logic                                         out_valid,
  output logic signed [plpu_pkg::VALUE_BITS-1:0]       out_data,
  output logic                                         out_zero
);

  localparam int VB = plpu_pkg::VALUE_BITS;
  localparam int DB = plpu_pkg::DIFF_BITS;
  localparam int MB = plpu_pkg::MAG_BITS;
  localparam int PB = plpu_pkg::PROD_BITS;
  localparam int SB = plpu_pkg::SUM_BITS;
  localparam int IB = plpu_pkg::IDX_BITS;
  localparam int NB = plpu_pkg::NUM_BITS;
  localparam int CB = plpu_pkg::CNT_BITS;

  localparam logic signed [SB-1:0] SAT_MAX = {{(SB - VB + 1){1'b0}}, {(VB - 1){1'b1}}};
  localparam logic signed [SB-1:0] SAT_MIN = ~SAT_MAX;
  localparam logic signed [VB-1:0] VAL_MAX = {1'b0, {(VB - 1){1'b1}}};
  localparam logic signed [VB-1:0] VAL_MIN = ~VAL_MAX;

  function automatic logic [MB-1:0] mag(input logic signed [DB-1:0] v);
    return v[DB-1] ? MB'(-v) : MB'(v);
  endfunction

  logic signed [VB-1:0] q_r;
  logic                 rev_r;
  logic [NB-1:0]        n_r;
  logic signed [VB-1:0] y0_r;
  logic                 falls_r;
  logic [IB-1:0]        idx_r;
  logic [IB-1:0]        s0_r;
  logic [CB-1:0]        cnt_r;
  logic signed [VB-1:0] e0x_r, e0y_r, e1x_r, e1y_r;
  logic signed [VB-1:0] p0_r;
  logic [MB-1:0]        dpm_r, dqm_r, dm_r;
  logic                 neg_r;
  logic                 zero_r;
  logic [PB-1:0]        prod_r;
  logic [MB-1:0]        rem_r;
  logic                 out_valid_r;
  logic signed [VB-1:0] out_data_r;
  logic                 out_zero_r;

  logic [NB-1:0]        n_clamp;
  logic                 falls_nxt;
  logic signed [VB-1:0] key;
  logic                 key_ge;
  logic [IB-1:0]        s1;
  logic signed [VB-1:0] p0, p1, c0, c1;
  logic signed [DB-1:0] dp_v, dq_v, d_v;
  logic [PB-1:0]        prod_nxt;
  logic [MB:0]          trial;
  logic                 ge;
  logic [MB-1:0]        rem_nxt;
  logic signed [SB-1:0] p0_ext, quot_ext, sum;
  logic signed [VB-1:0] result;
  logic                 out_free;

  always_comb begin
    if (points < plpu_pkg::POINTS_W'(2)) begin
      n_clamp = NB'(2);
    end else if (32'(points) > plpu_pkg::MAX_POINTS) begin
      n_clamp = NB'(plpu_pkg::MAX_POINTS);
    end else begin
      n_clamp = NB'(points);
    end
  end

  // Table falls from first to last point: reverse search walks down from the end.
  assign falls_nxt = rev_r && (y0_r > rd_y);
  assign key       = rev_r ? rd_y : rd_x;
  assign key_ge    = !(q_r < key);
  assign s1        = falls_r ? s0_r - 1'b1 : s0_r + 1'b1;

  always_comb begin
    unique case (op)
      plpu_pkg::OP_RD_LAST: rd_idx = IB'(n_r - NB'(1));
      plpu_pkg::OP_SRCH_RD: rd_idx = idx_r;
      plpu_pkg::OP_SEG_RD0: rd_idx = s0_r;
      plpu_pkg::OP_SEG_RD1: rd_idx = s1;
      default:              rd_idx = '0;
    endcase
  end

  // Forward maps x to y; reverse swaps the roles of the two coordinates.
  assign p0   = rev_r ? e0x_r : e0y_r;
  assign p1   = rev_r ? e1x_r : e1y_r;
  assign c0   = rev_r ? e0y_r : e0x_r;
  assign c1   = rev_r ? e1y_r : e1x_r;
  assign dp_v = DB'(p1) - DB'(p0);
  assign dq_v = DB'(q_r) - DB'(c0);
  assign d_v  = DB'(c1) - DB'(c0);

  assign prod_nxt = dpm_r * dqm_r;

  // Restoring division, one quotient bit per step; quotient shifts in behind the dividend.
  assign trial   = {rem_r, prod_r[PB-1]};
  assign ge      = trial >= {1'b0, dm_r};
  assign rem_nxt = ge ? MB'(trial - {1'b0, dm_r}) : MB'(trial);

  assign p0_ext   = SB'(p0_r);
  assign quot_ext = $signed({2'b00, prod_r});
  assign sum      = neg_r ? p0_ext - quot_ext : p0_ext + quot_ext;

  always_comb begin
    if (zero_r) begin
      result = p0_r;
    end else if (sum > SAT_MAX) begin
      result = VAL_MAX;
    end else if (sum < SAT_MIN) begin
      result = VAL_MIN;
    end else begin
      result = sum[VB-1:0];
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    case (op)
      plpu_pkg::OP_IDLE: begin
        if (start) begin
          q_r   <= query;
          rev_r <= start_rev;
          n_r   <= n_clamp;
        end
      end
      plpu_pkg::OP_RD_LAST: begin
        y0_r <= rd_y;
      end
      plpu_pkg::OP_DIR: begin
        falls_r <= falls_nxt;
        idx_r   <= falls_nxt ? IB'(n_r - NB'(2)) : IB'(1);
        s0_r    <= falls_nxt ? IB'(n_r - NB'(1)) : '0;
        cnt_r   <= CB'(n_r - NB'(2));
      end
      plpu_pkg::OP_SRCH_CMP: begin
        if (key_ge) begin
          s0_r  <= idx_r;
          idx_r <= falls_r ? idx_r - 1'b1 : idx_r + 1'b1;
          cnt_r <= cnt_r - 1'b1;
        end
      end
      plpu_pkg::OP_SEG_RD1: begin
        e0x_r <= rd_x;
        e0y_r <= rd_y;
      end
      plpu_pkg::OP_SEG_LATCH: begin
        e1x_r <= rd_x;
        e1y_r <= rd_y;
      end
      plpu_pkg::OP_DIFF: begin
        p0_r   <= p0;
        dpm_r  <= mag(dp_v);
        dqm_r  <= mag(dq_v);
        dm_r   <= mag(d_v);
        neg_r  <= dp_v[DB-1] ^ dq_v[DB-1] ^ d_v[DB-1];
        zero_r <= (d_v == '0);
      end
      plpu_pkg::OP_MUL: begin
        prod_r <= prod_nxt;
        rem_r  <= '0;
        cnt_r  <= CB'(PB - 1);
      end
      plpu_pkg::OP_DIV: begin
        prod_r <= {prod_r[PB-2:0], ge};
        rem_r  <= rem_nxt;
        cnt_r  <= cnt_r - 1'b1;
      end
      plpu_pkg::OP_FIN: begin
        if (out_free) begin
          out_data_r <= result;
          out_zero_r <= zero_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == plpu_pkg::OP_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.start     = start;
  assign status.cnt_zero  = (cnt_r == '0);
  assign status.key_ge    = key_ge;
  assign status.span_zero = zero_r;
  assign status.out_free  = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_zero  = out_zero_r;

endmodule

`default_nettype wire

FILE: src/piecewise_linear_profile_unit.sv
// Piecewise-linear profile unit, top level: stream ports, configuration register and
// wiring of plpu_seq, plpu_dp and plpu_table. Depends on plpu_pkg.
`default_nettype none

// A load beat writes one (x,y) breakpoint. A forward (x to y) or reverse (y to x) query
// beat is run by a microcoded sequencer: steps RD_FIRST, RD_LAST and DIR fetch the end
// points, the segment search reads one table entry per SRCH_RD/SRCH_CMP pair (up to n-2
// entries), SEG_RD0, SEG_RD1, SEG_LATCH, DIFF and MUL fetch the segment, form the
// differences and multiply, and a restoring divider then produces one quotient bit per
// cycle of its 66-bit quotient; a zero-width segment skips the divider. No new input
// beat is taken while a query runs. The result sits in an output register, so the next
// input beat is taken while it waits.
module piecewise_linear_profile_unit (
  input  wire                                    clk,
  input  wire                                    rst_n,
  // configuration: points_in_use
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire  [plpu_pkg::POINTS_W-1:0]          cfg_data,
  // input stream
  input  wire                                    in_tvalid,
  output logic                                   in_tready,
  // point_index, point_x, point_y, query_value, zero fill
  input  wire  [plpu_pkg::IN_DATA_BITS-1:0]      in_tdata,
  // action
  input  wire  [plpu_pkg::ACTION_W-1:0]          in_tuser,
  // result stream
  output logic                                   out_tvalid,
  input  wire                                    out_tready,
  // mapped_value, zero fill
  output logic [plpu_pkg::OUT_DATA_BITS-1:0]     out_tdata,
  // zero_span
  output logic [0:0]                             out_tuser
);

  localparam int VB = plpu_pkg::VALUE_BITS;
  localparam int IW = plpu_pkg::INDEX_W;

  logic [plpu_pkg::POINTS_W-1:0]   points_r;
  plpu_pkg::uword_t                uw;
  plpu_pkg::status_t               status;
  logic                            accept;
  logic                            start;
  logic                            wr_en;
  logic [IW-1:0]                   point_index;
  logic signed [VB-1:0]            point_x, point_y, query_value;
  logic [plpu_pkg::IDX_BITS-1:0]   rd_idx;
  logic signed [VB-1:0]            rd_x, rd_y;
  logic signed [VB-1:0]            mapped_value;
  logic                            zero_span;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= plpu_pkg::POINTS_RESET;
    end else if (cfg_valid) begin
      points_r <= cfg_data;
    end
  end

  assign point_index = in_tdata[IW-1:0];
  assign point_x     = in_tdata[IW+VB-1:IW];
  assign point_y     = in_tdata[IW+2*VB-1:IW+VB];
  assign query_value = in_tdata[IW+3*VB-1:IW+2*VB];

  assign in_tready = (uw.op == plpu_pkg::OP_IDLE);
  assign accept    = in_tvalid && in_tready;
  // Drop loads past the table and the unused action code.
  assign wr_en     = accept && (in_tuser == plpu_pkg::ACT_LOAD)
                     && (32'(point_index) < plpu_pkg::MAX_POINTS);
  assign start     = accept && (in_tuser == plpu_pkg::ACT_FWD || in_tuser == plpu_pkg::ACT_REV);

  plpu_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .uw     (uw)
  );

  plpu_table u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_idx (plpu_pkg::IDX_BITS'(point_index)),
    .wr_x   (point_x),
    .wr_y   (point_y),
    .rd_idx (rd_idx),
    .rd_x   (rd_x),
    .rd_y   (rd_y)
  );

  plpu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (uw.op),
    .start     (start),
    .start_rev (in_tuser == plpu_pkg::ACT_REV),
    .query     (query_value),
    .points    (points_r),
    .rd_x      (rd_x),
    .rd_y      (rd_y),
    .rd_idx    (rd_idx),
    .status    (status),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (mapped_value),
    .out_zero  (zero_span)
  );

  assign out_tdata = plpu_pkg::OUT_DATA_BITS'($unsigned(mapped_value));
  assign out_tuser = zero_span;

endmodule

`default_nettype wire

FILE: sim/plpu_profile_checker.sv
// Scoreboard for the piecewise-linear profile unit: mirrors the breakpoint table and
// the point count, predicts each query result and compares it with the result stream.
// Depends on plpu_pkg for field widths and action codes.
module plpu_profile_checker
  import plpu_pkg::*;
(
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_valid,
  input  wire                          cfg_ready,
  input  wire  [POINTS_W-1:0]          cfg_data,
  input  wire                          in_tvalid,
  input  wire                          in_tready,
  // point_index, point_x, point_y, query_value, zero fill
  input  wire  [IN_DATA_BITS-1:0]      in_tdata,
  // action
  input  wire  [ACTION_W-1:0]          in_tuser,
  input  wire                          out_tvalid,
  input  wire                          out_tready,
  // mapped_value, zero fill
  input  wire  [OUT_DATA_BITS-1:0]     out_tdata,
  // zero_span
  input  wire  [0:0]                   out_tuser,
  output int                           mismatches,
  output int                           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW = VALUE_BITS;
  localparam int DW = VW + 1;
  localparam int PW = 2 * DW;
  localparam logic [PW-1:0] QUOT_CAP = {{(PW-1){1'b0}}, 1'b1} << 62;
  localparam logic signed [PW-1:0] SAT_HI = {{(PW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [PW-1:0] SAT_LO = {{(PW-VW+1){1'b1}}, {(VW-1){1'b0}}};

  typedef struct packed {
    logic [VW-1:0] value;
    logic          zero_span;
  } mapped_t;

  logic signed [VW-1:0] table_x [MAX_POINTS];
  logic signed [VW-1:0] table_y [MAX_POINTS];
  logic [POINTS_W-1:0]  points_cfg;
  mapped_t              pending_maps [$];

  // p0 + (p1 - p0) * (qv - q0) / (q1 - q0), quotient toward zero and capped at 2^62, sum saturated
  function automatic mapped_t interpolate(input logic signed [VW-1:0] p0, p1, q0, q1, qv);
    logic signed [DW-1:0] dp, dq, span;
    logic [DW-1:0]        mp, mq, ms;
    logic [PW-1:0]        prod, quot;
    logic signed [PW-1:0] acc;
    mapped_t              r;
    dp   = {p1[VW-1], p1} - {p0[VW-1], p0};
    dq   = {qv[VW-1], qv} - {q0[VW-1], q0};
    span = {q1[VW-1], q1} - {q0[VW-1], q0};
    if (span == '0) begin
      r.value     = p0;
      r.zero_span = 1'b1;
      return r;
    end
    mp   = dp[DW-1] ? -dp : dp;
    mq   = dq[DW-1] ? -dq : dq;
    ms   = span[DW-1] ? -span : span;
    prod = mp * mq;
    quot = prod / ms;
    if (quot > QUOT_CAP) quot = QUOT_CAP;
    acc = {{(PW-VW){p0[VW-1]}}, p0};
    if (dp[DW-1] ^ dq[DW-1] ^ span[DW-1]) acc = acc - quot;
    else acc = acc + quot;
    if (acc > SAT_HI) acc = SAT_HI;
    if (acc < SAT_LO) acc = SAT_LO;
    r.value     = acc[VW-1:0];
    r.zero_span = 1'b0;
    return r;
  endfunction

  function automatic mapped_t predict_query(input logic [ACTION_W-1:0] act,
                                            input logic signed [VW-1:0] qv);
    int n;
    int s0;
    int s1;
    n = (points_cfg < 2) ? 2 : (points_cfg > MAX_POINTS) ? MAX_POINTS : int'(points_cfg);
    if (act == ACT_FWD) begin
      s0 = 0;
      for (int i = 1; i <= n - 2; i++) begin
        if (qv < table_x[i]) break;
        s0 = i;
      end
      return interpolate(table_y[s0], table_y[s0+1], table_x[s0], table_x[s0+1], qv);
    end
    // falling profile: search from the last point toward the first
    if (table_y[0] > table_y[n-1]) begin
      s0 = n - 1;
      for (int i = n - 2; i >= 1; i--) begin
        if (qv < table_y[i]) break;
        s0 = i;
      end
      s1 = s0 - 1;
    end else begin
      s0 = 0;
      for (int i = 1; i <= n - 2; i++) begin
        if (qv < table_y[i]) break;
        s0 = i;
      end
      s1 = s0 + 1;
    end
    return interpolate(table_x[s0], table_x[s1], table_y[s0], table_y[s1], qv);
  endfunction

  task automatic log_failure(input string what, input mapped_t want, input mapped_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected value %h zero_span %b, got value %h zero_span %b",
               $time, what, want.value, want.zero_span, got.value, got.zero_span);
  endtask

  always @(posedge clk) begin : track
    mapped_t got;
    mapped_t want;
    logic [INDEX_W-1:0] slot;
    if (!rst_n) begin
      points_cfg  = POINTS_RESET;
      mismatches  = 0;
      pending_maps.delete();
    end else begin
      if (cfg_valid && cfg_ready) points_cfg = cfg_data;
      if (out_tvalid && out_tready) begin
        got.value     = out_tdata[VW-1:0];
        got.zero_span = out_tuser[0];
        if (pending_maps.size() == 0) begin
          log_failure("result beat with nothing pending", '0, got);
        end else begin
          want = pending_maps.pop_front();
          if (got !== want) log_failure("result mismatch", want, got);
        end
      end
      if (in_tvalid && in_tready) begin
        slot = in_tdata[INDEX_W-1:0];
        case (in_tuser)
          ACT_LOAD: begin
            table_x[slot] = in_tdata[INDEX_W +: VW];
            table_y[slot] = in_tdata[INDEX_W+VW +: VW];
          end
          ACT_FWD, ACT_REV: begin
            pending_maps.push_back(predict_query(in_tuser, in_tdata[INDEX_W+2*VW +: VW]));
          end
          default: ;
        endcase
      end
    end
    outstanding = pending_maps.size();
  end

endmodule

FILE: sim/testbench.sv
// Top of the profile unit simulation: clock, reset, stimulus phases with varied point
// counts and idling, and the verdict. Depends on plpu_pkg, the unit and plpu_profile_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VB = plpu_pkg::VALUE_BITS;
  localparam int IW = plpu_pkg::INDEX_W;
  localparam int PW = plpu_pkg::POINTS_W;
  localparam int AW = plpu_pkg::ACTION_W;
  localparam int DW = plpu_pkg::IN_DATA_BITS;
  localparam int MP = plpu_pkg::MAX_POINTS;

  // action code the unit ignores
  localparam logic [AW-1:0] ACT_NONE = 2'd3;
  localparam int SETTLE_CYCLES   = 150;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 215;
  localparam logic [VB-1:0] V_MAX = 32'h7FFF_FFFF;
  localparam logic [VB-1:0] V_MIN = 32'h8000_0000;
  localparam logic [VB-1:0] ONE   = 32'h0001_0000;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     cfg_valid  = 1'b0;
  logic [PW-1:0]            cfg_data   = plpu_pkg::POINTS_RESET;
  logic                     in_tvalid  = 1'b0;
  logic [DW-1:0]            in_tdata   = '0;
  logic [AW-1:0]            in_tuser   = plpu_pkg::ACT_LOAD;
  logic                     out_tready = 1'b1;
  wire                      cfg_ready;
  wire                      in_tready;
  wire                      out_tvalid;
  wire [plpu_pkg::OUT_DATA_BITS-1:0] out_tdata;
  wire [0:0]                out_tuser;

  int mismatches;
  int outstanding;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int idle_cycles   = 0;
  int active_points = 2;
  logic signed [VB-1:0] shadow_x [MP];
  logic signed [VB-1:0] shadow_y [MP];

  piecewise_linear_profile_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  plpu_profile_checker profile_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Hold the beat until accepted; valid stays high on return for back-to-back beats.
  task automatic send_beat(input logic [AW-1:0] act, input logic [IW-1:0] slot,
                           input logic [VB-1:0] px, py, qv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{(DW-IW-3*VB){1'b0}}, qv, py, px, slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic load_point(input logic [IW-1:0] slot, input logic [VB-1:0] px, py);
    shadow_x[slot] = px;
    shadow_y[slot] = py;
    send_beat(plpu_pkg::ACT_LOAD, slot, px, py, $urandom);
  endtask

  task automatic ask(input logic [AW-1:0] act, input logic [VB-1:0] qv);
    send_beat(act, IW'($urandom), $urandom, $urandom, qv);
  endtask

  task automatic skip_beat();
    send_beat(ACT_NONE, IW'($urandom), $urandom, $urandom, $urandom);
  endtask

  // Drop valid, drain every pending result, then let a trailing load finish.
  task automatic quiesce();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_points(input logic [PW-1:0] value);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    active_points = (value < 2) ? 2 : (value > MP) ? MP : int'(value);
  endtask

  function automatic logic [VB-1:0] pick_extreme();
    case ($urandom_range(4))
      0:       return V_MIN;
      1:       return V_MAX;
      2:       return '0;
      3:       return '1;
      default: return ONE;
    endcase
  endfunction

  // Load slots 0..n-1: mostly sorted x with monotone or jittered y, some noise tables.
  task automatic build_table();
    logic [VB-1:0] px;
    logic [VB-1:0] py;
    int unsigned step_x;
    int unsigned step_y;
    int style;
    int slope;
    style  = $urandom_range(9);
    slope  = $urandom_range(2);
    px     = $urandom_range(32'h3FFF_FFFF) - 32'h2000_0000;
    py     = $urandom_range(32'h3FFF_FFFF) - 32'h2000_0000;
    step_x = 1 << $urandom_range(26, 2);
    step_y = 1 << $urandom_range(26, 2);
    for (int i = 0; i < active_points; i++) begin
      case (style)
        8: begin
          px = $urandom;
          py = $urandom;
        end
        9: begin
          px = pick_extreme();
          py = pick_extreme();
        end
        default: begin
          if (i > 0) begin
            // repeat an x now and then to get a zero-width segment
            if ($urandom_range(9) != 0) px = px + $urandom_range(step_x);
            if (style >= 6) py = $urandom;
            else if (slope == 0) py = py + $urandom_range(step_y);
            else if (slope == 1) py = py - $urandom_range(step_y);
            else py = py + $urandom_range(step_y) - step_y / 2;
          end
        end
      endcase
      load_point(IW'(i), px, py);
    end
  endtask

  task automatic ask_random();
    logic [AW-1:0]   act;
    logic [VB-1:0]   anchor;
    logic [VB-1:0]   qv;
    int unsigned     spread;
    int              i;
    act    = $urandom_range(1) ? plpu_pkg::ACT_FWD : plpu_pkg::ACT_REV;
    i      = $urandom_range(active_points - 1);
    anchor = (act == plpu_pkg::ACT_FWD) ? shadow_x[i] : shadow_y[i];
    spread = 1 << $urandom_range(24);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: qv = anchor + $urandom_range(spread) - spread / 2;
      5:             qv = anchor;
      6, 7:          qv = $urandom;
      default:       qv = pick_extreme();
    endcase
    ask(act, qv);
  endtask

  initial begin : stimulus
    logic [PW-1:0] phase_points [PHASES];
    int count;
    int pick;
    phase_points = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd9, 5'd17, 5'd1, 5'd5};
    phase_points[PHASES-1] = PW'($urandom_range(15, 3));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // two points at reset count: interior, extrapolation, saturation
    load_point(IW'(0), '0, '0);
    load_point(IW'(1), ONE, ONE << 1);
    ask(plpu_pkg::ACT_FWD, 32'h0000_8000);
    ask(plpu_pkg::ACT_FWD, V_MIN);
    ask(plpu_pkg::ACT_FWD, V_MAX);
    ask(plpu_pkg::ACT_REV, ONE);
    // falling y: reverse search runs from the last point
    load_point(IW'(0), V_MIN, V_MAX);
    load_point(IW'(1), V_MAX, V_MIN);
    ask(plpu_pkg::ACT_REV, '0);
    ask(plpu_pkg::ACT_REV, V_MAX);
    ask(plpu_pkg::ACT_REV, V_MIN);
    ask(plpu_pkg::ACT_FWD, '0);
    // steep segment: quotient clamps, then the sum saturates both ways
    load_point(IW'(0), '0, V_MIN);
    load_point(IW'(1), 32'd1, V_MAX);
    ask(plpu_pkg::ACT_FWD, V_MAX);
    ask(plpu_pkg::ACT_FWD, V_MIN);
    // zero-width segments in x, then in y
    load_point(IW'(1), '0, ONE * 5);
    ask(plpu_pkg::ACT_FWD, ONE);
    load_point(IW'(1), ONE, V_MIN);
    ask(plpu_pkg::ACT_REV, '0);
    skip_beat();
    ask(plpu_pkg::ACT_FWD, -ONE);

    for (int p = 0; p < PHASES; p++) begin
      write_points(phase_points[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      count = 0;
      while (count < ITEMS_PER_PHASE) begin
        build_table();
        count += active_points;
        repeat ($urandom_range(30, 6)) begin
          pick = $urandom_range(19);
          if (pick == 0) begin
            skip_beat();
          end else if (pick == 1) begin
            load_point(IW'($urandom), $urandom, $urandom);
            count++;
          end else begin
            ask_random();
            count++;
          end
        end
      end
    end

    quiesce();
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
